@@ rtl/cau_pkg.sv @@
//------------------------------------------------------------------------------
// cau_pkg
// Shared types, widths and saturation helpers for the complex arithmetic unit.
//------------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;          // product / sum-of-squares width
    localparam int QBITS  = DATA_W + 1;          // quotient bits produced by the divider
    localparam int HI_SH  = QBITS - FRAC_W;      // numerator bits above the quotient window
    localparam int ROOT_W = PROD_W / 2;          // bits of the integer square root
    localparam int SREM_W = ROOT_W + 2;          // square-root remainder width
    localparam int MAG_W  = PROD_W + 2;          // magnitude width for saturation

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CNJ = 3'd4,
        OP_MOD = 3'd5,
        OP_EQU = 3'd6
    } op_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } sat_t;

    // Clip a sign/magnitude value to the signed DATA_W range.
    function automatic sat_t sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] m;
        sat_t             r;
        lim = neg ? (MAG_W'(1) << (DATA_W - 1)) : ((MAG_W'(1) << (DATA_W - 1)) - MAG_W'(1));
        m   = mag;
        r.sat = 1'b0;
        if (mag > lim)
        begin
            m     = lim;
            r.sat = 1'b1;
        end
        r.val = neg ? (~m[DATA_W-1:0] + DATA_W'(1)) : m[DATA_W-1:0];
        return r;
    endfunction

    function automatic sat_t sat_signed(input logic signed [MAG_W-1:0] v);
        logic             neg;
        logic [MAG_W-1:0] mag;
        neg = v[MAG_W-1];
        mag = neg ? (~v + MAG_W'(1)) : v;
        return sat_mag(neg, mag);
    endfunction

endpackage

`default_nettype wire

@@ rtl/complex_arithmetic_unit.sv @@
//------------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined Q16.16 complex add, subtract, multiply, divide, conjugate,
// modulus and compare, with round-to-nearest and saturation.
//------------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------------
//  in      | in_valid  | in_stall  | operation, a_real, a_imag, b_real, b_imag
//  out     | out_valid | out_stall | res_real, res_imag, is_equal, divide_by_zero,
//          |           |           | saturated
//
// One item enters per cycle while the output is not stalled; the 33-stage
// radix-2 divider / square-root chain follows the input, product, sum and setup stages.
// Every operation travels the full pipe so results leave in order.
// A stalled output holds the whole pipe; in_stall follows out_stall while
// an item waits at the output. Reset empties the pipe.
//------------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [2:0]                     operation,
    input  wire logic signed [cau_pkg::DATA_W-1:0] a_real,
    input  wire logic signed [cau_pkg::DATA_W-1:0] a_imag,
    input  wire logic signed [cau_pkg::DATA_W-1:0] b_real,
    input  wire logic signed [cau_pkg::DATA_W-1:0] b_imag,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [cau_pkg::DATA_W-1:0]   res_real,
    output logic signed [cau_pkg::DATA_W-1:0]   res_imag,
    output logic                                is_equal,
    output logic                                divide_by_zero,
    output logic                                saturated
);
    import cau_pkg::*;

    localparam int NSTEP = QBITS;        // chain stages (covers ROOT_W too)
    localparam int NVLD  = NSTEP + 5;    // s0, s1, s2, chain 0..NSTEP, output

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              eq;
        logic              dz;
        logic              sat;
    } early_t;

    typedef struct packed {
        early_t            e;
        logic              neg_re;
        logic              neg_im;
        logic              ovf_re;
        logic              ovf_im;
        logic [PROD_W-1:0] d;
        logic [PROD_W-1:0] rem_re;
        logic [PROD_W-1:0] rem_im;
        logic [QBITS-1:0]  nlo_re;
        logic [QBITS-1:0]  nlo_im;
        logic [QBITS-1:0]  q_re;
        logic [QBITS-1:0]  q_im;
        logic [PROD_W-1:0] x;
        logic [SREM_W-1:0] srem;
        logic [ROOT_W-1:0] root;
    } ch_t;

    // one restoring-division bit for both parts and, while root_en, one
    // square-root bit (the root is done after ROOT_W steps)
    function automatic ch_t ch_step(input ch_t c, input logic root_en);
        logic [PROD_W:0]   t_re;
        logic [PROD_W:0]   t_im;
        logic              ge_re;
        logic              ge_im;
        logic [SREM_W+1:0] r2;
        logic [SREM_W+1:0] ts;
        logic              ge_s;
        ch_t               n;
        n     = c;
        t_re  = {c.rem_re, c.nlo_re[QBITS-1]};
        t_im  = {c.rem_im, c.nlo_im[QBITS-1]};
        ge_re = t_re >= {1'b0, c.d};
        ge_im = t_im >= {1'b0, c.d};
        n.rem_re = ge_re ? PROD_W'(t_re - {1'b0, c.d}) : t_re[PROD_W-1:0];
        n.rem_im = ge_im ? PROD_W'(t_im - {1'b0, c.d}) : t_im[PROD_W-1:0];
        n.nlo_re = c.nlo_re << 1;
        n.nlo_im = c.nlo_im << 1;
        n.q_re   = {c.q_re[QBITS-2:0], ge_re};
        n.q_im   = {c.q_im[QBITS-2:0], ge_im};
        r2   = {c.srem, c.x[PROD_W-1 -: 2]};
        ts   = (SREM_W+2)'({c.root, 2'b01});
        ge_s = r2 >= ts;
        n.x  = c.x << 2;
        if (root_en)
        begin
            n.srem = ge_s ? SREM_W'(r2 - ts) : r2[SREM_W-1:0];
            n.root = {c.root[ROOT_W-2:0], ge_s};
        end
        return n;
    endfunction

    logic              en;
    logic [NVLD-1:0]   vld_reg;

    // stage 0: captured operands
    op_t                      op0_reg;
    logic signed [DATA_W-1:0] ar_reg, ai_reg, br_reg, bi_reg;

    // stage 1: products
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PROD_W-1:0] p_br2_reg, p_bi2_reg, p_ar2_reg, p_ai2_reg;
    early_t                   e1_reg;
    early_t                   e1_next;

    // stage 2: sums
    logic signed [PROD_W:0]   s_re_reg, s_im_reg;
    logic [PROD_W-1:0]        d_reg, x_reg;
    early_t                   e2_reg;

    // chain
    ch_t                      ch_reg [0:NSTEP];
    ch_t                      ch0_next;

    // output
    logic [DATA_W-1:0]        res_re_reg, res_im_reg;
    logic                     eq_reg, dz_reg, sat_reg;
    logic [DATA_W-1:0]        res_re_next, res_im_next;
    logic                     eq_next, dz_next, sat_next;

    assign in_stall = vld_reg[NVLD-1] & out_stall;
    assign en       = ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NVLD-2:0], in_valid};
        end
    end

    // early results for add, subtract, conjugate, compare and the divide-by-zero check
    always_comb
    begin
        sat_t sr;
        sat_t si;
        sr = sat_signed(MAG_W'(ar_reg) + MAG_W'(br_reg));
        si = sat_signed(MAG_W'(ai_reg) + MAG_W'(bi_reg));
        e1_next    = '0;
        e1_next.op = op0_reg;
        case (op0_reg)
            OP_ADD:
            begin
                sr = sat_signed(MAG_W'(ar_reg) + MAG_W'(br_reg));
                si = sat_signed(MAG_W'(ai_reg) + MAG_W'(bi_reg));
                e1_next.re  = sr.val;
                e1_next.im  = si.val;
                e1_next.sat = sr.sat | si.sat;
            end
            OP_SUB:
            begin
                sr = sat_signed(MAG_W'(ar_reg) - MAG_W'(br_reg));
                si = sat_signed(MAG_W'(ai_reg) - MAG_W'(bi_reg));
                e1_next.re  = sr.val;
                e1_next.im  = si.val;
                e1_next.sat = sr.sat | si.sat;
            end
            OP_CNJ:
            begin
                si = sat_signed(-MAG_W'(ai_reg));
                e1_next.re  = ar_reg;
                e1_next.im  = si.val;
                e1_next.sat = si.sat;
            end
            OP_DIV:
            begin
                // zero divisor: dividend passes through
                e1_next.dz = (br_reg == '0) && (bi_reg == '0);
                e1_next.re = ar_reg;
                e1_next.im = ai_reg;
            end
            OP_EQU:
            begin
                e1_next.eq = (ar_reg == br_reg) && (ai_reg == bi_reg);
            end
            default:
            begin
                e1_next.op = op0_reg;
            end
        endcase
    end

    // multiply rounding and divider / root setup
    always_comb
    begin
        logic              nr, ni;
        logic [PROD_W:0]   mr, mi;
        sat_t              sr, si;
        logic [PROD_W-1:0] hr, hi;
        nr = s_re_reg[PROD_W];
        ni = s_im_reg[PROD_W];
        mr = nr ? (~s_re_reg + (PROD_W+1)'(1)) : s_re_reg;
        mi = ni ? (~s_im_reg + (PROD_W+1)'(1)) : s_im_reg;
        sr = sat_mag(nr, (MAG_W'(mr) + (MAG_W'(1) << (FRAC_W - 1))) >> FRAC_W);
        si = sat_mag(ni, (MAG_W'(mi) + (MAG_W'(1) << (FRAC_W - 1))) >> FRAC_W);
        hr = PROD_W'(mr >> HI_SH);
        hi = PROD_W'(mi >> HI_SH);
        ch0_next        = '0;
        ch0_next.e      = e2_reg;
        if (e2_reg.op == OP_MUL)
        begin
            ch0_next.e.re  = sr.val;
            ch0_next.e.im  = si.val;
            ch0_next.e.sat = sr.sat | si.sat;
        end
        ch0_next.neg_re = nr;
        ch0_next.neg_im = ni;
        ch0_next.d      = d_reg;
        ch0_next.ovf_re = hr >= d_reg;
        ch0_next.ovf_im = hi >= d_reg;
        ch0_next.rem_re = (hr >= d_reg) ? '0 : hr;
        ch0_next.rem_im = (hi >= d_reg) ? '0 : hi;
        ch0_next.nlo_re = {mr[HI_SH-1:0], FRAC_W'(0)};
        ch0_next.nlo_im = {mi[HI_SH-1:0], FRAC_W'(0)};
        ch0_next.x      = x_reg;
    end

    // final rounding, saturation and selection
    always_comb
    begin
        ch_t               c;
        logic [QBITS:0]    qr, qi;
        logic [ROOT_W:0]   rt;
        sat_t              sr, si, sm;
        c  = ch_reg[NSTEP];
        qr = (QBITS+1)'(c.q_re) + (QBITS+1)'({c.rem_re, 1'b0} >= {1'b0, c.d});
        qi = (QBITS+1)'(c.q_im) + (QBITS+1)'({c.rem_im, 1'b0} >= {1'b0, c.d});
        rt = (ROOT_W+1)'(c.root) + (ROOT_W+1)'(c.srem > SREM_W'(c.root));
        sr = sat_mag(c.neg_re, c.ovf_re ? '1 : MAG_W'(qr));
        si = sat_mag(c.neg_im, c.ovf_im ? '1 : MAG_W'(qi));
        sm = sat_mag(1'b0, MAG_W'(rt));
        res_re_next = c.e.re;
        res_im_next = c.e.im;
        eq_next     = c.e.eq;
        dz_next     = c.e.dz;
        sat_next    = c.e.sat;
        if (c.e.op == OP_DIV && !c.e.dz)
        begin
            res_re_next = sr.val;
            res_im_next = si.val;
            sat_next    = sr.sat | si.sat;
        end
        else if (c.e.op == OP_MOD)
        begin
            res_re_next = sm.val;
            res_im_next = '0;
            sat_next    = sm.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg <= op_t'(operation);
            ar_reg  <= a_real;
            ai_reg  <= a_imag;
            br_reg  <= b_real;
            bi_reg  <= b_imag;

            p_rr_reg  <= ar_reg * br_reg;
            p_ii_reg  <= ai_reg * bi_reg;
            p_ri_reg  <= ar_reg * bi_reg;
            p_ir_reg  <= ai_reg * br_reg;
            p_br2_reg <= br_reg * br_reg;
            p_bi2_reg <= bi_reg * bi_reg;
            p_ar2_reg <= ar_reg * ar_reg;
            p_ai2_reg <= ai_reg * ai_reg;
            e1_reg    <= e1_next;

            if (e1_reg.op == OP_MUL)
            begin
                s_re_reg <= (PROD_W+1)'(p_rr_reg) - (PROD_W+1)'(p_ii_reg);
                s_im_reg <= (PROD_W+1)'(p_ri_reg) + (PROD_W+1)'(p_ir_reg);
            end
            else
            begin
                s_re_reg <= (PROD_W+1)'(p_rr_reg) + (PROD_W+1)'(p_ii_reg);
                s_im_reg <= (PROD_W+1)'(p_ir_reg) - (PROD_W+1)'(p_ri_reg);
            end
            d_reg  <= $unsigned(p_br2_reg) + $unsigned(p_bi2_reg);
            x_reg  <= $unsigned(p_ar2_reg) + $unsigned(p_ai2_reg);
            e2_reg <= e1_reg;

            ch_reg[0] <= ch0_next;
            for (int k = 0; k < NSTEP; k++)
            begin
                ch_reg[k+1] <= ch_step(ch_reg[k], k < ROOT_W);
            end

            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            eq_reg     <= eq_next;
            dz_reg     <= dz_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid      = vld_reg[NVLD-1];
    assign res_real       = res_re_reg;
    assign res_imag       = res_im_reg;
    assign is_equal       = eq_reg;
    assign divide_by_zero = dz_reg;
    assign saturated      = sat_reg;

    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> !saturated && !is_equal)
        else $error("divide by zero result carries other flags");

    a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_equal |-> res_real == '0 && res_imag == '0 && !saturated)
        else $error("compare result carries data");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vld_reg))
        else $error("pipe moved while output stalled");

endmodule

`default_nettype wire
